@@ hdl/page_replacement_fifo_lru_defines.svh @@
// Assertion macros shared by the page replacement block.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_DEFINES_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define PRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define PRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/prf_pkg.sv @@
// Package: sizes, types and structs of the page replacement block.
package prf_pkg;

    localparam int FRAMES     = 4;
    localparam int PAGE_BITS  = 16;
    localparam int AGE_BITS   = 16;
    localparam int COUNT_BITS = 32;
    localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // Fixed field widths of the stream beats
    localparam int IN_PAGE_W   = 16;
    localparam int OUT_FRAME_W = 2;
    localparam int OUT_PAGE_W  = 16;
    localparam int OUT_W       = 1 + OUT_FRAME_W + 1 + OUT_PAGE_W + COUNT_BITS;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic
    {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } policy_t;

    typedef logic [FRAME_BITS-1:0] slot_t;
    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [AGE_BITS-1:0]   age_t;

    // Lookup results handed from cell to cell
    typedef struct packed
    {
        logic  hit;
        slot_t hit_idx;
        logic  empty;
        slot_t empty_idx;
        age_t  best_age;
        slot_t best_idx;
    } chain_t;

    // Update command broadcast to every cell
    typedef struct packed
    {
        logic  acc;
        logic  fill;
        logic  clr_age;
        slot_t slot;
        page_t page;
    } cmd_t;

endpackage

@@ hdl/prf_cell.sv @@
// One frame cell: holds valid, page and age, extends the lookup chain.
module prf_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  prf_pkg::slot_t  cell_idx,
    input  prf_pkg::page_t  look_page,
    input  prf_pkg::cmd_t   cmd,
    input  prf_pkg::chain_t chain_in,
    output prf_pkg::chain_t chain_out,
    output prf_pkg::page_t  page
);

    logic           valid_reg, valid_next;
    prf_pkg::page_t page_reg, page_next;
    prf_pkg::age_t  age_reg, age_next;
    logic           match;
    logic           sel;

    assign match = valid_reg && (page_reg == look_page);
    assign page  = page_reg;

    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.hit && match)
        begin
            chain_out.hit     = 1'b1;
            chain_out.hit_idx = cell_idx;
        end
        if (!chain_in.empty && !valid_reg)
        begin
            chain_out.empty     = 1'b1;
            chain_out.empty_idx = cell_idx;
        end
        // strict compare keeps the lowest index on a tie
        if (age_reg > chain_in.best_age)
        begin
            chain_out.best_age = age_reg;
            chain_out.best_idx = cell_idx;
        end
    end

    assign sel = cmd.acc && (cmd.slot == cell_idx);

    always_comb
    begin
        valid_next = valid_reg;
        page_next  = page_reg;
        age_next   = age_reg;
        if (cmd.acc)
        begin
            if (sel && (cmd.fill || cmd.clr_age))
            begin
                // cleared, then aged once in the same access
                age_next = prf_pkg::age_t'(1);
            end
            else if (age_reg != '1)
            begin
                age_next = age_reg + prf_pkg::age_t'(1);
            end
            if (sel && cmd.fill)
            begin
                valid_next = 1'b1;
                page_next  = cmd.page;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

@@ hdl/page_replacement_fifo_lru.sv @@
// Top level: FIFO/LRU page replacement over a chain of frame cells.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: page
//  m_axis   | out | m_axis_tvalid/tready    | tdata: hit, frame, evicted_valid,
//           |     |                         |        evicted_page, fault_count
//  cfg      | in  | cfg_wr_en               | cfg_wr_data: policy_mode
//
// One page reference per cycle unless stalled; a registered result follows its
// input beat. The per-beat path is the lookup chain through the FRAMES cells
// (page compare, first-empty and oldest-age search ripple cell to cell).
// Reset clears valid marks, ages, fault count and policy (FIFO); no sweep.
// A stalled result holds s_axis_tready low unless it is taken in that cycle.
`include "page_replacement_fifo_lru_defines.svh"

module page_replacement_fifo_lru
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,    // policy_mode
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [prf_pkg::IN_PAGE_W-1:0]   s_axis_tdata,   // [15:0] page
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [prf_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [0] hit, [2:1] frame,
                                                            // [3] evicted_valid,
                                                            // [19:4] evicted_page,
                                                            // [51:20] fault_count
);

    prf_pkg::policy_t policy_reg;

    logic                                  out_vld_reg, out_vld_next;
    logic [prf_pkg::OUT_TDATA_W-1:0]       out_data_reg, out_data_next;
    logic [prf_pkg::COUNT_BITS-1:0]        fault_reg, fault_next;

    prf_pkg::chain_t chain [prf_pkg::FRAMES+1];
    prf_pkg::page_t  cell_page [prf_pkg::FRAMES];
    prf_pkg::page_t  look_page;
    prf_pkg::cmd_t   cmd;
    prf_pkg::slot_t  slot;
    prf_pkg::page_t  old_page;
    logic            accept;
    logic            hit;
    logic            evict;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= prf_pkg::POLICY_FIFO;
        end
        else if (cfg_wr_en)
        begin
            policy_reg <= prf_pkg::policy_t'(cfg_wr_data);
        end
    end

    // output register doubles as the stall point
    assign s_axis_tready = !out_vld_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign look_page     = prf_pkg::page_t'(s_axis_tdata);

    // lookup chain: seed, then one cell per frame
    assign chain[0] = '0;

    for (genvar i = 0; i < prf_pkg::FRAMES; i++)
    begin : g_cell
        prf_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (prf_pkg::slot_t'(i)),
            .look_page (look_page),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .page      (cell_page[i])
        );
    end

    // slot choice: hit, else first empty, else oldest
    always_comb
    begin
        hit   = chain[prf_pkg::FRAMES].hit;
        evict = !hit && !chain[prf_pkg::FRAMES].empty;
        if (hit)
        begin
            slot = chain[prf_pkg::FRAMES].hit_idx;
        end
        else if (!evict)
        begin
            slot = chain[prf_pkg::FRAMES].empty_idx;
        end
        else
        begin
            slot = chain[prf_pkg::FRAMES].best_idx;
        end
    end

    assign old_page = evict ? cell_page[slot] : '0;

    always_comb
    begin
        cmd.acc     = accept;
        cmd.fill    = !hit;
        cmd.clr_age = hit && (policy_reg == prf_pkg::POLICY_LRU);
        cmd.slot    = slot;
        cmd.page    = look_page;
    end

    // saturating miss counter, result beat
    always_comb
    begin
        fault_next    = fault_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (accept && !hit && (fault_reg != '1))
        begin
            fault_next = fault_reg + prf_pkg::COUNT_BITS'(1);
        end
        if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (accept)
        begin
            out_vld_next  = 1'b1;
            out_data_next = prf_pkg::OUT_TDATA_W'({
                fault_next,
                prf_pkg::OUT_PAGE_W'(old_page),
                evict,
                prf_pkg::OUT_FRAME_W'(slot),
                hit
            });
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            fault_reg   <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            fault_reg   <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    `PRF_ASSERT_NEXT(a_beat_out, accept, out_vld_reg, "accepted beat gave no result")
    `PRF_ASSERT_NOW(a_hit_no_evict, accept && hit, !evict, "hit with eviction")
    `PRF_ASSERT_NEXT(a_fault_inc, accept && !hit && (fault_reg != '1),
        fault_reg == $past(fault_reg) + prf_pkg::COUNT_BITS'(1), "miss not counted")
    `PRF_ASSERT_NEXT(a_fault_hold, !(accept && !hit), $stable(fault_reg),
        "fault count moved without a miss")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the FIFO/LRU page replacement block.
`timescale 1ns / 100ps

module tb;

    localparam int WDOG_LIMIT = 1000;   // cycles with no beat on either side
    localparam int HOLD_HITS  = 20;     // same-page FIFO hits before the next miss

    // Result beat, hit in bit 0 up to fault_count at the top
    typedef struct packed
    {
        logic [prf_pkg::COUNT_BITS-1:0]  fault_count;
        logic [prf_pkg::OUT_PAGE_W-1:0]  evicted_page;
        logic                            evicted_valid;
        logic [prf_pkg::OUT_FRAME_W-1:0] frame;
        logic                            hit;
    } access_t;

    // Directed row: result is typed in only where fixed is set
    typedef struct packed
    {
        prf_pkg::page_t   page;
        prf_pkg::policy_t pol;
        logic             fixed;
        access_t          want;
    } dir_row_t;

    localparam int DIR_ROWS = 16;
    dir_row_t dir_rows [DIR_ROWS] = '{
        // cold fills from reset: misses go to the lowest empty frame
        '{16'h0000, prf_pkg::POLICY_FIFO, 1'b1, '{32'd1, 16'h0000, 1'b0, 2'd0, 1'b0}},
        '{16'hFFFF, prf_pkg::POLICY_FIFO, 1'b1, '{32'd2, 16'h0000, 1'b0, 2'd1, 1'b0}},
        '{16'h0000, prf_pkg::POLICY_FIFO, 1'b1, '{32'd2, 16'h0000, 1'b0, 2'd0, 1'b1}},
        '{16'h5555, prf_pkg::POLICY_FIFO, 1'b1, '{32'd3, 16'h0000, 1'b0, 2'd2, 1'b0}},
        '{16'hAAAA, prf_pkg::POLICY_FIFO, 1'b1, '{32'd4, 16'h0000, 1'b0, 2'd3, 1'b0}},
        // full: FIFO evicts by fill order, hits do not clear ages
        '{16'h1234, prf_pkg::POLICY_FIFO, 1'b0, '0},
        '{16'hFFFF, prf_pkg::POLICY_FIFO, 1'b0, '0},
        '{16'h8000, prf_pkg::POLICY_FIFO, 1'b0, '0},
        // LRU: hits clear the age and protect the frame
        '{16'h5555, prf_pkg::POLICY_LRU,  1'b0, '0},
        '{16'h5555, prf_pkg::POLICY_LRU,  1'b0, '0},
        '{16'h0001, prf_pkg::POLICY_LRU,  1'b0, '0},
        '{16'hAAAA, prf_pkg::POLICY_LRU,  1'b0, '0},
        '{16'hFFFE, prf_pkg::POLICY_LRU,  1'b0, '0},
        '{16'h0001, prf_pkg::POLICY_LRU,  1'b0, '0},
        '{16'h7FFF, prf_pkg::POLICY_LRU,  1'b0, '0},
        '{16'h5555, prf_pkg::POLICY_LRU,  1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [prf_pkg::IN_PAGE_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [prf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor state
    prf_pkg::policy_t               policy = prf_pkg::POLICY_FIFO;
    logic                           mem_valid [prf_pkg::FRAMES];
    prf_pkg::page_t                 mem_page [prf_pkg::FRAMES];
    prf_pkg::age_t                  mem_age [prf_pkg::FRAMES];
    logic [prf_pkg::COUNT_BITS-1:0] miss_total = '0;

    access_t pending_results [$];
    int      fail_count = 0;

    // Traffic shaping
    bit             idle_on = 1'b0;
    int             burst_left = 0;
    logic [15:0]    stall_pat = '1;    // 1 = ready
    logic [3:0]     stall_pos = '0;
    prf_pkg::page_t pool [8];
    int             pool_n = 4;
    int             quiet_cycles = 0;

    page_replacement_fifo_lru i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One reference: hit lookup, else first empty frame, else oldest frame
    function automatic access_t replace_page(input prf_pkg::page_t pg);
        access_t       r;
        int            slot;
        bit            found;
        prf_pkg::age_t best;
        r     = '0;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < prf_pkg::FRAMES; i++)
        begin
            if (!found && mem_valid[i] && mem_page[i] == pg)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            if (policy == prf_pkg::POLICY_LRU)
                mem_age[slot] = '0;
        end
        else
        begin
            for (int i = 0; i < prf_pkg::FRAMES; i++)
            begin
                if (!found && !mem_valid[i])
                begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (!found)
            begin
                // strict compare keeps the lowest index on a tie
                best = '0;
                slot = 0;
                for (int i = 0; i < prf_pkg::FRAMES; i++)
                begin
                    if (mem_age[i] > best)
                    begin
                        best = mem_age[i];
                        slot = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = mem_page[slot];
            end
            mem_valid[slot] = 1'b1;
            mem_page[slot]  = pg;
            mem_age[slot]   = '0;
            if (miss_total != '1)
                miss_total++;
        end
        for (int i = 0; i < prf_pkg::FRAMES; i++)
        begin
            if (mem_age[i] != '1)
                mem_age[i]++;
        end
        r.frame       = slot[prf_pkg::OUT_FRAME_W-1:0];
        r.fault_count = miss_total;
        return r;
    endfunction

    // Mostly a small working set so hits and evictions mix, some noise
    function automatic prf_pkg::page_t pick_page();
        case ($urandom_range(0, 9))
            0, 1:    return prf_pkg::page_t'($urandom);
            2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return pool[$urandom_range(0, pool_n - 1)];
        endcase
    endfunction

    // Drive one beat, hold until taken, then log its expected result
    task automatic send_page(input prf_pkg::page_t pg, input bit fixed,
                             input access_t want);
        access_t r;
        int      gap;
        if (burst_left == 0)
        begin
            gap        = idle_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pg;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = replace_page(pg);
        if (fixed)
            r = want;
        pending_results.push_back(r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Only called with the block idle
    task automatic write_policy(input prf_pkg::policy_t p);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        policy = p;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Receiver stalls on a rotating pattern
    always @(posedge clk)
    begin
        stall_pos     <= stall_pos + 4'd1;
        m_axis_tready <= stall_pat[stall_pos];
    end

    // Result checker
    always @(posedge clk)
    begin
        access_t want;
        access_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = access_t'(m_axis_tdata[prf_pkg::OUT_W-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(got.hit));
                check_field("frame", 32'(want.frame), 32'(got.frame));
                check_field("evicted_valid", 32'(want.evicted_valid),
                            32'(got.evicted_valid));
                check_field("evicted_page", 32'(want.evicted_page),
                            32'(got.evicted_page));
                check_field("fault_count", want.fault_count, got.fault_count);
                check_field("pad", 32'd0,
                            32'(m_axis_tdata[prf_pkg::OUT_TDATA_W-1:prf_pkg::OUT_W]));
            end
        end
    end

    // Watchdog: no beat on either side for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || cfg_wr_en)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        prf_pkg::page_t hold_page;
        for (int i = 0; i < prf_pkg::FRAMES; i++)
        begin
            mem_valid[i] = 1'b0;
            mem_page[i]  = '0;
            mem_age[i]   = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, back to back; policy switches only when drained
        write_policy(prf_pkg::POLICY_FIFO);
        foreach (dir_rows[n])
        begin
            if (dir_rows[n].pol != policy)
            begin
                wait_drained();
                write_policy(dir_rows[n].pol);
            end
            send_page(dir_rows[n].page, dir_rows[n].fixed, dir_rows[n].want);
        end

        // FIFO hold: a run of hits on one page never clears its age, so the
        // next miss still evicts in fill order
        wait_drained();
        write_policy(prf_pkg::POLICY_FIFO);
        for (int k = 0; k < prf_pkg::FRAMES; k++)
            send_page(prf_pkg::page_t'(16'h0100 + k), 1'b0, '0);
        hold_page = 16'h0100;
        repeat (HOLD_HITS) send_page(hold_page, 1'b0, '0);
        send_page(16'hBEEF, 1'b0, '0);
        send_page(16'h0101, 1'b0, '0);

        // Random segments, alternating policy, idling on after the first
        for (int seg = 0; seg < 4; seg++)
        begin
            wait_drained();
            write_policy(seg[0] ? prf_pkg::POLICY_FIFO : prf_pkg::POLICY_LRU);
            idle_on    = (seg != 0);
            burst_left = 0;
            stall_pat  = idle_on ? (16'($urandom) | 16'h0001) : '1;
            pool_n     = $urandom_range(3, 7);
            for (int k = 0; k < pool_n; k++)
                pool[k] = prf_pkg::page_t'($urandom);
            repeat (90) send_page(pick_page(), 1'b0, '0);
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/prf_pkg.sv
hdl/prf_cell.sv
hdl/page_replacement_fifo_lru.sv
sim/tb.sv
